[sv/wsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

  localparam logic [31:0] MixInit = 32'hEEEEEEEE;
  localparam logic [31:0] KeyAdd  = 32'h11111111;

  typedef struct packed {
    logic [31:0] cipher_word;
    logic        first_word;
    logic        last_word;
  } wsd_in_t;

  typedef struct packed {
    logic [31:0] plain_word;
    logic        last_out;
  } wsd_out_t;

  localparam logic [31:0] CryptRom [256] = '{
    32'd423274136, 32'd1419179989, 32'd1107858203, 32'd2051081964, -32'sd2081920960, -32'sd191139956, -32'sd1170367919, 32'd1442139613,
    32'd769987442, -32'sd1694804197, 32'd984830982, -32'sd1385890017, -32'sd948476674, 32'd2139505766, 32'd1097702612, -32'sd1572302216,
    -32'sd485783836, 32'd189936054, -32'sd1167610154, -32'sd441768857, 32'd1610779536, 32'd496902342, 32'd712796458, 32'd1802050779,
    -32'sd1638795241, -32'sd1686749716, 32'd1026110015, -32'sd807326872, 32'd1967867291, -32'sd1574731705, -32'sd641379052, 32'd1809645505,
    32'd1765696320, -32'sd2110242841, 32'd420932191, -32'sd327430823, 32'd1927157338, -32'sd409332201, -32'sd1899470284, -32'sd1460612476,
    32'd550044198, 32'd2079950980, 32'd681935665, 32'd1053031022, 32'd1289783643, -32'sd1017924400, 32'd871302735, 32'd568713744,
    -32'sd927246179, -32'sd396506446, -32'sd1402633569, -32'sd1480617264, 32'd94771021, 32'd631573550, -32'sd439908489, 32'd1031078431,
    32'd1269472408, 32'd599640196, -32'sd1772897321, -32'sd1159927819, -32'sd1031560060, -32'sd1069490386, -32'sd1821333439, 32'd791765026,
    32'd921621041, -32'sd1406354420, 32'd331392155, -32'sd841930345, 32'd134123954, -32'sd847336499, 32'd738273053, 32'd407055864,
    32'd1503423431, 32'd1978219866, -32'sd1233490206, -32'sd1905029610, -32'sd7310339, -32'sd1351155094, -32'sd126967044, -32'sd1856987485,
    32'd866618822, 32'd1333338954, 32'd980759996, 32'd892992689, 32'd822341202, 32'd1332682345, 32'd1806953404, 32'd1287091541,
    -32'sd1915623015, 32'd719209373, 32'd290594734, -32'sd1186126523, -32'sd1914791235, 32'd420034879, -32'sd1215126979, 32'd1956398427,
    -32'sd1246359764, 32'd939809230, 32'd229464096, -32'sd1322220453, 32'd689749330, -32'sd560309321, 32'd1373567329, 32'd1364943880,
    -32'sd898727362, 32'd942567028, -32'sd289522319, 32'd1284443242, -32'sd428417814, 32'd350346364, 32'd1870644788, -32'sd813323965,
    -32'sd744576658, 32'd326007955, 32'd1902424836, -32'sd215018701, 32'd901988404, -32'sd566634719, -32'sd1851231175, -32'sd1005580001,
    32'd703691436, 32'd320251647, 32'd317822190, 32'd1108055193, -32'sd148000548, 32'd1762369427, 32'd399592370, -32'sd1886184776,
    32'd561316028, -32'sd2024533000, -32'sd1733106627, -32'sd987785871, 32'd1422835146, 32'd119131257, -32'sd205060083, -32'sd467114127,
    -32'sd1544899635, 32'd1248526560, 32'd298780505, 32'd2122937209, 32'd1530038124, 32'd1586287862, 32'd216922724, -32'sd1852128569,
    -32'sd1307249741, 32'd243909516, -32'sd255575495, -32'sd354351838, -32'sd2091135482, -32'sd1628683326, -32'sd366564906, 32'd1767053345,
    32'd1730523722, -32'sd629034782, -32'sd709579213, 32'd135240187, 32'd363347375, 32'd702531360, -32'sd1847488497, 32'd672546136,
    -32'sd2083453022, 32'd1319900314, -32'sd1619928552, 32'd1641399546, -32'sd475321761, -32'sd944712129, -32'sd1278446294, 32'd1642844086,
    32'd654292266, -32'sd310862273, -32'sd1438922408, 32'd1163560840, -32'sd910130519, 32'd169602830, -32'sd1030071682, 32'd353191733,
    -32'sd1808266784, 32'd1763792144, -32'sd284488279, 32'd995008435, -32'sd659173300, -32'sd945806424, -32'sd1328217464, 32'd1686246261,
    -32'sd1033836337, -32'sd2070495956, -32'sd11578315, 32'd263542284, 32'd2094484050, -32'sd1822909312, -32'sd2003346361, -32'sd2084722531,
    -32'sd1949547882, 32'd28847137, -32'sd41804353, 32'd642911047, 32'd77086233, -32'sd740177369, 32'd2016172047, 32'd846198131,
    -32'sd1051214649, 32'd1331587972, 32'd1156316155, -32'sd634988072, 32'd1826214030, 32'd387576280, 32'd1901855879, 32'd741162130,
    32'd1408936873, -32'sd1132240570, 32'd1359778518, -32'sd527828950, 32'd1182799647, 32'd916390110, 32'd1894523697, 32'd237321557,
    -32'sd621045993, -32'sd438463955, -32'sd1785635551, -32'sd1608503402, -32'sd1587426233, -32'sd355490063, -32'sd312569463, -32'sd625445244,
    -32'sd1531482806, -32'sd93304681, 32'd1662980282, -32'sd744642311, 32'd1572126948, 32'd385737770, 32'd771716480, -32'sd1250956162,
    -32'sd1006652560, -32'sd1905314116, 32'd1620563033, 32'd1364024630, -32'sd1515767838, 32'd964147635, -32'sd47079222, -32'sd1875679013,
    -32'sd399045279, -32'sd1743743712, -32'sd1377682260, -32'sd1711788540, 32'd1105100451, -32'sd2069773675, 32'd152640480, 32'd814943490,
    32'd480224330, -32'sd1006192937, -32'sd287530670, 32'd1632207004, -32'sd1341546764, -32'sd973712475, 32'd1276147981, 32'd1929586796
  };

endpackage
`default_nettype wire

[sv/word_stream_decrypt.sv]
`timescale 1ns / 1ps
`default_nettype none
// Word stream decryptor: one plain word per cipher word, one transaction per
// cycle unless out_ready_i stalls a full output; the result register holds
// the word in the cycle after input is accepted. first_word reloads the state
// from 0xEEEEEEEE and block_key. The key table lookup and state adds are
// combinational before the result register; block_key_we_i loads the key.
module word_stream_decrypt (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             block_key_we_i,
  input  wire logic [31:0]      block_key_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wsd_pkg::wsd_in_t      in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output wsd_pkg::wsd_out_t     out_data_o
);
  import wsd_pkg::*;

  logic [31:0] key_cfg_q;
  logic [31:0] mix_q, key_q;
  logic [31:0] mix_src, key_src, plain_w, mix_d, key_d;
  logic        out_valid_q;
  wsd_out_t    out_q;
  logic        in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mix_src     = in_data_i.first_word ? MixInit : mix_q;
  assign key_src     = in_data_i.first_word ? key_cfg_q : key_q;

  wsd_core u_core (
    .mix_i    (mix_src),
    .key_i    (key_src),
    .cipher_i (in_data_i.cipher_word),
    .plain_o  (plain_w),
    .mix_o    (mix_d),
    .key_o    (key_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cfg_q   <= '0;
      mix_q       <= MixInit;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (block_key_we_i) key_cfg_q <= block_key_i;
      if (in_fire) begin
        mix_q <= mix_d;
        key_q <= key_d;
      end
      if (in_ready_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.plain_word <= plain_w;
      out_q.last_out   <= in_data_i.last_word;
    end
  end
endmodule
`default_nettype wire

[sv/wsd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsd_core (
  input  wire logic [31:0] mix_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] cipher_i,
  output logic      [31:0] plain_o,
  output logic      [31:0] mix_o,
  output logic      [31:0] key_o
);
  import wsd_pkg::*;

  logic [31:0] rom_w;
  logic [31:0] sum_w;

  always_comb begin
    rom_w   = CryptRom[key_i[7:0]];
    plain_o = cipher_i ^ (mix_i + key_i + rom_w);
    sum_w   = mix_i + rom_w;
    mix_o   = sum_w + (sum_w << 5) + plain_o + 32'd3;
    key_o   = (key_i >> 11) | (((~key_i) << 21) + KeyAdd);
  end
endmodule
`default_nettype wire

[sv/wsd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module wsd_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wsd_pkg::wsd_in_t      in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wsd_pkg::wsd_out_t     out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction lost");
  a_last_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_data_o.last_out == $past(in_data_i.last_word))
    else $error("last flag mismatch");
endmodule

bind word_stream_decrypt wsd_checker u_wsd_checker (.*);
`default_nettype wire
